// ===== hdl/utf16_to_utf8_converter_unit_assert.svh =====
// Assertion helpers used by the converter RTL
`ifndef UTF16_TO_UTF8_CONVERTER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int CAP_W      = 31;
  localparam int FLAG_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int NB_W       = 3;

  localparam logic [FLAG_W-1:0] VALID_FLAGS = 32'h0000_06F0;
  localparam logic [FLAG_W-1:0] STRICT_FLAG = 32'h0000_0080;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLAGS    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_NUL = 2'd2;

  localparam logic [NB_W-1:0] MAX_BYTES = 3'd6;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_PARAM   = 3'd1,
    ERR_BUFFER  = 3'd2,
    ERR_FLAGS   = 3'd3,
    ERR_NO_XLAT = 3'd4
  } err_code_t;

  typedef logic [3:0][7:0] char_bytes_t;   // byte 0 goes out first
  typedef logic [5:0][7:0] byte_list_t;

  // running per-beat conversion state
  typedef struct packed {
    logic             ok;
    logic             ovf;
    logic [CNT_W-1:0] cnt;
    byte_list_t       obytes;
    logic [NB_W-1:0]  nb;
  } acc_t;

  localparam char_bytes_t REPL_CHAR = {8'h00, 8'hBD, 8'hBF, 8'hEF};

  // BMP code point (not a surrogate) to UTF-8
  function automatic char_bytes_t enc_bmp(logic [15:0] c);
    char_bytes_t r;
    if (c < 16'h0080) begin
      r = {24'd0, c[7:0]};
    end else if (c < 16'h0800) begin
      r = {16'd0, 2'b10, c[5:0], 3'b110, c[10:6]};
    end else begin
      r = {8'd0, 2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end
    return r;
  endfunction

  function automatic logic [NB_W-1:0] len_bmp(logic [15:0] c);
    logic [NB_W-1:0] r;
    if (c < 16'h0080) r = 3'd1;
    else if (c < 16'h0800) r = 3'd2;
    else r = 3'd3;
    return r;
  endfunction

  // surrogate pair to 4-byte UTF-8
  function automatic char_bytes_t enc_pair(logic [9:0] hi, logic [9:0] lo);
    logic [20:0] cp;
    cp = {1'b0, hi, lo} + 21'h01_0000;
    return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
  endfunction

  // one character: count, bounds check, and append its bytes
  function automatic acc_t emit_char(acc_t a, char_bytes_t ch, logic [NB_W-1:0] len,
                                     logic [CAP_W-1:0] cap);
    acc_t          r;
    logic [CNT_W:0] sum;
    logic [NB_W-1:0] pos;
    r    = a;
    r.ok = 1'b0;
    sum  = {1'b0, a.cnt} + {{(CNT_W+1-NB_W){1'b0}}, len};
    if (!a.ovf) begin
      if (cap == '0) begin
        // measuring: count only, saturate
        r.ok  = 1'b1;
        r.cnt = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
      end else if (sum > {2'b00, cap}) begin
        r.ovf = 1'b1;
      end else begin
        r.ok  = 1'b1;
        r.cnt = sum[CNT_W-1:0];
        for (int i = 0; i < 4; i++) begin
          pos = a.nb + NB_W'(i);
          if (NB_W'(i) < len && pos < MAX_BYTES) r.obytes[pos] = ch[i];
        end
        r.nb = a.nb + len;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/utf16_to_utf8_converter_unit.sv =====
// UTF-16 to UTF-8 converter. One code unit enters per in_ beat; its UTF-8 bytes
// leave as out_ beats with out_tuser low, and the unit flagged by in_tlast also
// yields a summary beat (out_tuser high) with the return count and error code.
// out_tlast marks the final beat caused by each input unit. A unit is converted
// in the cycle it is accepted and its beats (up to seven) are loaded into one
// output buffer that drains a beat per cycle while out_tready is high; the input
// is held until the last beat, and the next unit is taken in the same cycle as
// that beat, so plain text at one byte per unit runs at one unit per cycle while
// out_tready stays high. Units that yield nothing (a held high surrogate, ignored
// units) load nothing. Capacity zero counts bytes without emitting them.
// Users must write registers only while the block is idle; nothing enforces it.
`include "utf16_to_utf8_converter_unit_assert.svh"

module utf16_to_utf8_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  // code unit stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // last_unit
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] out_byte, [38:8] return_count,
                                  // [41:39] error_code, [42] used_replacement
  output logic        out_tuser,  // record_kind
  output logic        out_tlast   // end_of_run
);

  localparam int CAP_W  = u16u8_pkg::CAP_W;
  localparam int FLAG_W = u16u8_pkg::FLAG_W;
  localparam int CNT_W  = u16u8_pkg::CNT_W;
  localparam int NB_W   = u16u8_pkg::NB_W;

  // configuration
  logic [CAP_W-1:0]  cap_r;
  logic [FLAG_W-1:0] flag_r;
  logic              stop_r;

  // stream state
  logic [9:0]        ph_r, ph_nxt;
  logic              hp_r, hp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  logic              rep_r, rep_nxt;
  logic              nul_r, nul_nxt;

  // output buffer
  logic                   busy_r;
  logic [NB_W-1:0]        idx_r;
  logic [NB_W-1:0]        tot_m1_r, tot_m1_nxt;
  u16u8_pkg::byte_list_t  obytes_r;
  logic [NB_W-1:0]        nb_r;
  logic                   sum_r, sum_nxt;
  logic [CAP_W-1:0]       ret_r, ret_nxt;
  u16u8_pkg::err_code_t   err_r, err_nxt;
  logic                   used_r, used_nxt;

  logic                   flags_bad;
  logic                   do_char;
  logic                   c_high, c_low;
  logic [15:0]            c;
  u16u8_pkg::acc_t        acc;
  logic                   accept, load, is_sum;

  assign c      = in_tdata;
  assign c_high = (c >= 16'hD800) && (c < 16'hDC00);
  assign c_low  = (c >= 16'hDC00) && (c < 16'hE000);

  // convert the unit at the input against current state
  always_comb begin
    flags_bad  = |(flag_r & ~u16u8_pkg::VALID_FLAGS);
    ph_nxt     = ph_r;
    hp_nxt     = hp_r;
    rep_nxt    = rep_r;
    nul_nxt    = nul_r;
    acc.ok     = 1'b0;
    acc.ovf    = ov_r;
    acc.cnt    = cnt_r;
    acc.obytes = '0;
    acc.nb     = '0;
    do_char    = 1'b1;
    sum_nxt    = 1'b0;
    ret_nxt    = '0;
    err_nxt    = u16u8_pkg::ERR_NONE;
    used_nxt   = 1'b0;

    if (!flags_bad && !ov_r && !nul_r) begin
      if (hp_r) begin
        hp_nxt = 1'b0;
        if (c_low) begin
          acc     = u16u8_pkg::emit_char(acc, u16u8_pkg::enc_pair(ph_r, c[9:0]), 3'd4, cap_r);
          do_char = 1'b0;
        end else begin
          // lone high surrogate replaced first
          rep_nxt = 1'b1;
          acc     = u16u8_pkg::emit_char(acc, u16u8_pkg::REPL_CHAR, 3'd3, cap_r);
          do_char = acc.ok;
        end
      end
      if (do_char) begin
        if (c_high) begin
          ph_nxt = c[9:0];
          hp_nxt = 1'b1;
        end else if (c_low) begin
          rep_nxt = 1'b1;
          acc     = u16u8_pkg::emit_char(acc, u16u8_pkg::REPL_CHAR, 3'd3, cap_r);
        end else begin
          acc = u16u8_pkg::emit_char(acc, u16u8_pkg::enc_bmp(c), u16u8_pkg::len_bmp(c),
                                     cap_r);
        end
      end
      if (stop_r && c == 16'h0000) nul_nxt = 1'b1;
    end

    if (in_tlast) begin
      // dangling high surrogate at end of string
      if (!flags_bad && !acc.ovf && hp_nxt) begin
        hp_nxt  = 1'b0;
        rep_nxt = 1'b1;
        acc     = u16u8_pkg::emit_char(acc, u16u8_pkg::REPL_CHAR, 3'd3, cap_r);
      end
      sum_nxt = 1'b1;
      if (flags_bad) begin
        err_nxt = u16u8_pkg::ERR_FLAGS;
      end else if (acc.ovf) begin
        err_nxt = u16u8_pkg::ERR_BUFFER;
      end else begin
        used_nxt = rep_nxt;
        if (rep_nxt && |(flag_r & u16u8_pkg::STRICT_FLAG)) err_nxt = u16u8_pkg::ERR_NO_XLAT;
        else if (acc.cnt[CNT_W-1]) err_nxt = u16u8_pkg::ERR_PARAM;
        else ret_nxt = acc.cnt[CAP_W-1:0];
      end
    end

    cnt_nxt = acc.cnt;
    ov_nxt  = acc.ovf;
    if (in_tlast) begin
      ph_nxt  = '0;
      hp_nxt  = 1'b0;
      cnt_nxt = '0;
      ov_nxt  = 1'b0;
      rep_nxt = 1'b0;
      nul_nxt = 1'b0;
    end

    tot_m1_nxt = acc.nb + NB_W'(sum_nxt) - 3'd1;
  end

  // handshake
  assign is_sum     = sum_r && (idx_r == nb_r);
  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == tot_m1_r);
  assign out_tuser  = is_sum;
  assign in_tready  = !busy_r || (out_tready && out_tlast);
  assign accept     = in_tvalid && in_tready;
  assign load       = accept && ((acc.nb != '0) || in_tlast);

  always_comb begin
    out_tdata = '0;
    if (is_sum) begin
      out_tdata[38:8]  = ret_r;
      out_tdata[41:39] = err_r;
      out_tdata[42]    = used_r;
    end else if (idx_r < u16u8_pkg::MAX_BYTES) begin
      out_tdata[7:0] = obytes_r[idx_r];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= '0;
      flag_r <= '0;
      stop_r <= 1'b0;
      ph_r   <= '0;
      hp_r   <= 1'b0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
      rep_r  <= 1'b0;
      nul_r  <= 1'b0;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          u16u8_pkg::REG_CAPACITY: cap_r  <= cfg_data[CAP_W-1:0];
          u16u8_pkg::REG_FLAGS:    flag_r <= cfg_data;
          u16u8_pkg::REG_STOP_NUL: stop_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        ph_r  <= ph_nxt;
        hp_r  <= hp_nxt;
        cnt_r <= cnt_nxt;
        ov_r  <= ov_nxt;
        rep_r <= rep_nxt;
        nul_r <= nul_nxt;
      end
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r && out_tready) begin
        if (out_tlast) busy_r <= 1'b0;
        else idx_r <= idx_r + 3'd1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (load) begin
      obytes_r <= acc.obytes;
      nb_r     <= acc.nb;
      tot_m1_r <= tot_m1_nxt;
      sum_r    <= sum_nxt;
      ret_r    <= ret_nxt;
      err_r    <= err_nxt;
      used_r   <= used_nxt;
    end
  end

  `UTU_ASSERT_IMP(a_sum_ends_run, out_tvalid && out_tuser, out_tlast,
                  "summary beat not marked as end of run")
  `UTU_ASSERT_NXT(a_last_gives_result, in_tvalid && in_tready && in_tlast, out_tvalid,
                  "no result pending after last unit")
  `UTU_ASSERT_NXT(a_last_clears, in_tvalid && in_tready && in_tlast,
                  cnt_r == '0 && !hp_r && !ov_r && !nul_r,
                  "stream state not cleared after last unit")
  `UTU_ASSERT_IMP(a_idx_range, busy_r, idx_r <= tot_m1_r && nb_r <= u16u8_pkg::MAX_BYTES,
                  "output index beyond loaded beats")

endmodule
